>>> sv/mrsf_pkg.sv
// ----------------------------------------------------------------------------
// Multi-reader sample FIFO package
// Shared sizes, codes, position-unit request and response structs and address helpers.
// ----------------------------------------------------------------------------
package mrsf_pkg;

    localparam int DEPTH     = 1024;
    localparam int READERS   = 8;
    localparam int BATCH_MAX = 64;
    localparam int POS_BITS  = 48;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RIDX_W = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int NRD_W  = $clog2(READERS + 1);
    localparam int CNT_W  = $clog2(BATCH_MAX + 1);

    localparam int SAMPLE_W   = 32;
    localparam int KIND_W     = 2;
    localparam int READER_W   = 3;
    localparam int STATUS_W   = 3;
    localparam int POS_OUT_W  = 48;
    localparam int AR_W       = 4;
    localparam int MB_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 80;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLOSE  = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_SAMPLE      = 3'd0,
        STAT_NO_DATA     = 3'd1,
        STAT_EOS         = 3'd2,
        STAT_APPEND_DONE = 3'd3,
        STAT_DROPPED     = 3'd4,
        STAT_BAD_READER  = 3'd5
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_READERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCH      = 2'd1;

    typedef enum logic {
        ALU_SUB = 1'b0,
        ALU_ADD = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t               op;
        logic [POS_BITS-1:0]   a;
        logic [POS_BITS-1:0]   b;
        logic [POS_BITS-1:0]   c;
    } alu_req_t;

    typedef struct packed {
        logic [POS_BITS-1:0]   res;
        logic                  lt;
        logic                  zero;
    } alu_rsp_t;

    // Physical address a plus an offset of at most DEPTH, wrapped into the store.
    function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W:0]   b);
        logic [ADDR_W+1:0] sum;
        sum = {2'b00, a} + {1'b0, b};
        if (sum >= (ADDR_W+2)'(DEPTH)) begin
            sum = sum - (ADDR_W+2)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [NRD_W-1:0] readers_in_use(input logic [AR_W-1:0] ar);
        logic [NRD_W-1:0] n;
        if (ar == '0) begin
            n = NRD_W'(1);
        end else if (32'(ar) > READERS) begin
            n = NRD_W'(READERS);
        end else begin
            n = NRD_W'(ar);
        end
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] batch_cap(input logic [MB_W-1:0] mb);
        logic [CNT_W-1:0] c;
        if (mb == '0 || 32'(mb) > BATCH_MAX) begin
            c = CNT_W'(BATCH_MAX);
        end else begin
            c = CNT_W'(mb);
        end
        return c;
    endfunction

endpackage

>>> sv/mrsf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/mrsf_alu.sv
// ----------------------------------------------------------------------------
// Shared position unit
// Wrapping add or subtract on stream positions, with a compare of the result.
// ----------------------------------------------------------------------------
module mrsf_alu (
    input  mrsf_pkg::alu_req_t req,
    output mrsf_pkg::alu_rsp_t rsp
);
    import mrsf_pkg::*;

    logic [POS_BITS-1:0] sum;

    always_comb begin
        unique case (req.op)
            ALU_ADD: sum = req.a + req.b;
            ALU_SUB: sum = req.a - req.b;
            default: sum = req.a - req.b;
        endcase
        rsp.res  = sum;
        rsp.lt   = (sum < req.c);
        rsp.zero = (sum == '0);
    end

endmodule

>>> sv/multi_reader_sample_fifo_unit.sv
// ----------------------------------------------------------------------------
// Multi-reader sample FIFO
// Circular sample store with one writer and several cursor-based readers.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_*       in         one command transaction: append, read, close or clear
//  m_*       out        result transactions: samples or one status word
//  cfg_*     in         register writes: active reader count, batch limit
//
//  Close and clear complete in the idle state; an append checks for space and
//  writes, with a status word at a burst end or on a drop. A read sends its samples,
//  then the shared position unit handles one cursor per cycle while oldest
//  entries are freed; every sample passes through the store read port.
//  Reset is synchronous and takes effect at once; the store is not cleared.
//  A stalled result side holds the sequencer; new commands wait in s_tready.
//
module multi_reader_sample_fifo_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: sample [31:0], reader [34:32], zero padding [39:35]
    input  logic [mrsf_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: kind [1:0]
    input  logic [mrsf_pkg::KIND_W-1:0]      s_tuser,
    input  logic                             s_tlast,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata: sample_res [31:0], position [79:32]
    output logic [mrsf_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: status [2:0]
    output logic [mrsf_pkg::STATUS_W-1:0]    m_tuser,
    output logic                             m_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mrsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mrsf_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_APP_CHK  = 13'b0000000000010,
        S_APP_WR   = 13'b0000000000100,
        S_RD_CHK   = 13'b0000000001000,
        S_RD_OFF   = 13'b0000000010000,
        S_RD_ADDR  = 13'b0000000100000,
        S_RD_ISSUE = 13'b0000001000000,
        S_RD_LOAD  = 13'b0000010000000,
        S_RD_CUR   = 13'b0000100000000,
        S_FR_FILL  = 13'b0001000000000,
        S_FR_SCAN  = 13'b0010000000000,
        S_FR_APPLY = 13'b0100000000000,
        S_RESP     = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [POS_BITS-1:0] cursor_reg  [READERS];
    logic [POS_BITS-1:0] cursor_next [READERS];
    logic [POS_BITS-1:0] write_count_reg, write_count_next;
    logic [POS_BITS-1:0] oldest_reg, oldest_next;
    logic [ADDR_W-1:0]   oldest_addr_reg, oldest_addr_next;
    logic                closed_reg, closed_next;
    logic [AR_W-1:0]     active_reg, active_next;
    logic [MB_W-1:0]     max_batch_reg, max_batch_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                burst_reg, burst_next;
    logic [READER_W-1:0] reader_reg, reader_next;
    logic [ADDR_W-1:0]   off_reg, off_next;
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [RIDX_W-1:0]   scan_reg, scan_next;
    status_t             resp_reg, resp_next;
    status_t             out_status_reg, out_status_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic [POS_OUT_W-1:0] out_pos_reg, out_pos_next;
    logic                out_last_reg, out_last_next;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic                ram_re;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic [NRD_W-1:0]    n_use;
    logic [NRD_W-1:0]    n_new;
    logic [CNT_W-1:0]    cap;
    logic [RIDX_W-1:0]   cur_idx;
    logic [POS_BITS-1:0] cur_val;
    logic                out_free;
    logic                out_load;
    logic                s_fire;
    logic                cfg_fire;

    mrsf_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    mrsf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (sample_reg),
        .rd_en   (ram_re),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign n_use     = readers_in_use(active_reg);
    assign n_new     = readers_in_use(cfg_data[AR_W-1:0]);
    assign cap       = batch_cap(max_batch_reg);
    assign cur_idx   = (state_reg == S_FR_SCAN) ? scan_reg : RIDX_W'(reader_reg);
    assign cur_val   = cursor_reg[cur_idx];
    assign ram_waddr = addr_add(oldest_addr_reg, {1'b0, off_reg});

    always_comb begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        write_count_next = write_count_reg;
        oldest_next      = oldest_reg;
        oldest_addr_next = oldest_addr_reg;
        closed_next      = closed_reg;
        active_next      = active_reg;
        max_batch_next   = max_batch_reg;
        sample_next      = sample_reg;
        burst_next       = burst_reg;
        reader_next      = reader_reg;
        off_next         = off_reg;
        rd_addr_next     = rd_addr_reg;
        pos_next         = pos_reg;
        lo_next          = lo_reg;
        cnt_next         = cnt_reg;
        k_next           = k_reg;
        scan_next        = scan_reg;
        resp_next        = resp_reg;
        out_status_next  = out_status_reg;
        out_sample_next  = out_sample_reg;
        out_pos_next     = out_pos_reg;
        out_last_next    = out_last_reg;
        out_load         = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        alu_req.op       = ALU_SUB;
        alu_req.a        = write_count_reg;
        alu_req.b        = oldest_reg;
        alu_req.c        = '0;

        if (cfg_fire) begin
            unique case (cfg_index)
                CFG_ACTIVE_READERS: begin
                    active_next = cfg_data[AR_W-1:0];
                    for (int i = 0; i < READERS; i++) begin
                        if (NRD_W'(i) >= n_use && NRD_W'(i) < n_new) begin
                            cursor_next[i] = oldest_reg;
                        end
                    end
                end
                CFG_MAX_BATCH: begin
                    max_batch_next = cfg_data[MB_W-1:0];
                end
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    unique case (kind_t'(s_tuser))
                        KIND_APPEND: begin
                            sample_next = s_tdata[SAMPLE_W-1:0];
                            burst_next  = s_tlast;
                            state_next  = S_APP_CHK;
                        end
                        KIND_READ: begin
                            reader_next = s_tdata[SAMPLE_W+READER_W-1:SAMPLE_W];
                            state_next  = S_RD_CHK;
                        end
                        KIND_CLOSE: begin
                            closed_next = 1'b1;
                        end
                        KIND_CLEAR: begin
                            for (int i = 0; i < READERS; i++) begin
                                cursor_next[i] = '0;
                            end
                            write_count_next = '0;
                            oldest_next      = '0;
                            oldest_addr_next = '0;
                            closed_next      = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_APP_CHK: begin
                alu_req.c = POS_BITS'(DEPTH);
                if (!alu_rsp.lt) begin
                    resp_next  = STAT_DROPPED;
                    state_next = S_RESP;
                end else begin
                    off_next   = alu_rsp.res[ADDR_W-1:0];
                    state_next = S_APP_WR;
                end
            end
            S_APP_WR: begin
                ram_we           = 1'b1;
                alu_req.op       = ALU_ADD;
                alu_req.b        = POS_BITS'(1);
                write_count_next = alu_rsp.res;
                if (burst_reg) begin
                    resp_next  = STAT_APPEND_DONE;
                    state_next = S_RESP;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_RD_CHK: begin
                alu_req.b = cur_val;
                alu_req.c = POS_BITS'(cap);
                if (8'(reader_reg) >= 8'(n_use)) begin
                    resp_next  = STAT_BAD_READER;
                    state_next = S_RESP;
                end else if (alu_rsp.zero) begin
                    resp_next  = closed_reg ? STAT_EOS : STAT_NO_DATA;
                    state_next = S_RESP;
                end else begin
                    cnt_next   = alu_rsp.lt ? CNT_W'(alu_rsp.res) : cap;
                    state_next = S_RD_OFF;
                end
            end
            S_RD_OFF: begin
                alu_req.a  = cur_val;
                off_next   = alu_rsp.res[ADDR_W-1:0];
                pos_next   = cur_val;
                state_next = S_RD_ADDR;
            end
            S_RD_ADDR: begin
                rd_addr_next = addr_add(oldest_addr_reg, {1'b0, off_reg});
                k_next       = '0;
                state_next   = S_RD_ISSUE;
            end
            S_RD_ISSUE: begin
                if (out_free) begin
                    ram_re     = 1'b1;
                    state_next = S_RD_LOAD;
                end
            end
            S_RD_LOAD: begin
                out_load        = 1'b1;
                out_status_next = STAT_SAMPLE;
                out_sample_next = ram_rdata;
                out_pos_next    = POS_OUT_W'(pos_reg);
                alu_req.op      = ALU_ADD;
                alu_req.a       = pos_reg;
                alu_req.b       = POS_BITS'(1);
                pos_next        = alu_rsp.res;
                rd_addr_next    = addr_add(rd_addr_reg, (ADDR_W+1)'(1));
                k_next          = k_reg + CNT_W'(1);
                if (k_reg + CNT_W'(1) == cnt_reg) begin
                    out_last_next = 1'b1;
                    state_next    = S_RD_CUR;
                end else begin
                    out_last_next = 1'b0;
                    state_next    = S_RD_ISSUE;
                end
            end
            S_RD_CUR: begin
                cursor_next[cur_idx] = pos_reg;
                state_next           = S_FR_FILL;
            end
            S_FR_FILL: begin
                lo_next    = alu_rsp.res;
                scan_next  = '0;
                state_next = S_FR_SCAN;
            end
            S_FR_SCAN: begin
                alu_req.a = cur_val;
                alu_req.c = lo_reg;
                if (alu_rsp.lt) begin
                    lo_next = alu_rsp.res;
                end
                if (NRD_W'(scan_reg) + NRD_W'(1) == n_use) begin
                    state_next = S_FR_APPLY;
                end else begin
                    scan_next = scan_reg + RIDX_W'(1);
                end
            end
            S_FR_APPLY: begin
                alu_req.op       = ALU_ADD;
                alu_req.a        = oldest_reg;
                alu_req.b        = lo_reg;
                oldest_next      = alu_rsp.res;
                oldest_addr_next = addr_add(oldest_addr_reg, lo_reg[ADDR_W:0]);
                state_next       = S_IDLE;
            end
            S_RESP: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_status_next = resp_reg;
                    out_sample_next = '0;
                    out_pos_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            for (int i = 0; i < READERS; i++) begin
                cursor_reg[i] <= '0;
            end
            write_count_reg <= '0;
            oldest_reg      <= '0;
            oldest_addr_reg <= '0;
            closed_reg      <= 1'b0;
            active_reg      <= AR_W'(1);
            max_batch_reg   <= MB_W'(BATCH_MAX);
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            write_count_reg <= write_count_next;
            oldest_reg      <= oldest_next;
            oldest_addr_reg <= oldest_addr_next;
            closed_reg      <= closed_next;
            active_reg      <= active_next;
            max_batch_reg   <= max_batch_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        burst_reg      <= burst_next;
        reader_reg     <= reader_next;
        off_reg        <= off_next;
        rd_addr_reg    <= rd_addr_next;
        pos_reg        <= pos_next;
        lo_reg         <= lo_next;
        cnt_reg        <= cnt_next;
        k_reg          <= k_next;
        scan_reg       <= scan_next;
        resp_reg       <= resp_next;
        out_status_reg <= out_status_next;
        out_sample_reg <= out_sample_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_pos_reg, out_sample_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register loaded while a transaction is pending");

    a_batch_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD_ISSUE) |-> (cnt_reg != '0 && cnt_reg <= cap))
        else $error("read batch length out of range");

    a_batch_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD_LOAD) |-> (k_reg < cnt_reg))
        else $error("sample count ran past the batch length");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FR_SCAN) |-> (NRD_W'(scan_reg) < n_use))
        else $error("cursor scan beyond the active readers");

endmodule

>>> dv/tb_multi_reader_sample_fifo_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multi-reader sample FIFO
// Drives append, read, close and clear commands with bursty input and a
// stalling result side. A shadow of the store and of every reader cursor
// predicts each result, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb_multi_reader_sample_fifo_unit;

    import mrsf_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int SETTLE   = 300;
    localparam int LIMIT    = 1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd2;

    typedef struct packed {
        status_t          status;
        logic [31:0]      sample;
        logic [47:0]      position;
        logic             last;
    } fifo_reply_t;

    class sample_fifo_shadow;
        logic [31:0]  store [DEPTH];
        logic [47:0]  cursor [READERS];
        logic [47:0]  written;
        logic [47:0]  oldest;
        int unsigned  oldest_addr;
        bit           closed;
        logic [3:0]   ar_reg;
        logic [6:0]   mb_reg;
        fifo_reply_t  replies [$];
        int unsigned  mismatches;
        int unsigned  checked;
        int unsigned  samples_seen;
        int unsigned  drops_seen;
        int unsigned  bad_seen;

        function new();
            clear_state();
            ar_reg = 4'd1;
            mb_reg = 7'd64;
        endfunction

        function void clear_state();
            foreach (store[i]) store[i] = '0;
            foreach (cursor[i]) cursor[i] = '0;
            written     = '0;
            oldest      = '0;
            oldest_addr = 0;
            closed      = 1'b0;
        endfunction

        function int unsigned live_readers();
            if (ar_reg == 0) return 1;
            if (ar_reg > READERS) return READERS;
            return 32'(ar_reg);
        endfunction

        function int unsigned slot(logic [47:0] offset);
            return (oldest_addr + 32'(offset)) % DEPTH;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int unsigned was;
            int unsigned now;
            if (idx == CFG_ACTIVE_READERS) begin
                was    = live_readers();
                ar_reg = data[3:0];
                now    = live_readers();
                for (int unsigned i = was; i < now; i++) cursor[i] = oldest;
            end else if (idx == CFG_MAX_BATCH) begin
                mb_reg = data[6:0];
            end
        endfunction

        function void push(status_t st, logic [31:0] smp, logic [47:0] pos, logic last);
            fifo_reply_t rep;
            rep.status   = st;
            rep.sample   = smp;
            rep.position = pos;
            rep.last     = last;
            replies.insert(replies.size(), rep);
        endfunction

        function void drop_consumed();
            logic [47:0] lo;
            logic [47:0] off;
            lo = written - oldest;
            for (int unsigned i = 0; i < live_readers(); i++) begin
                off = cursor[i] - oldest;
                if (off < lo) lo = off;
            end
            oldest_addr = slot(lo);
            oldest      = oldest + lo;
        endfunction

        function void apply_command(kind_t kind, logic [31:0] smp, logic burst_end,
                                    logic [2:0] rdr);
            logic [47:0]  fill;
            logic [47:0]  avail;
            logic [47:0]  off;
            int unsigned  cap;
            int unsigned  r;
            case (kind)
                KIND_APPEND: begin
                    fill = written - oldest;
                    if (fill >= DEPTH) begin
                        push(STAT_DROPPED, '0, '0, 1'b1);
                    end else begin
                        store[slot(fill)] = smp;
                        written = written + 1;
                        if (burst_end) push(STAT_APPEND_DONE, '0, '0, 1'b1);
                    end
                end
                KIND_READ: begin
                    r = 32'(rdr);
                    if (r >= live_readers()) begin
                        push(STAT_BAD_READER, '0, '0, 1'b1);
                    end else begin
                        avail = written - cursor[r];
                        if (avail == 0) begin
                            push(closed ? STAT_EOS : STAT_NO_DATA, '0, '0, 1'b1);
                        end else begin
                            cap = (mb_reg == 0 || mb_reg > BATCH_MAX) ? BATCH_MAX : mb_reg;
                            if (avail > cap) avail = 48'(cap);
                            off = cursor[r] - oldest;
                            for (int unsigned k = 0; k < avail; k++) begin
                                push(STAT_SAMPLE, store[slot(off + k)], cursor[r] + k,
                                     k + 1 == avail);
                            end
                            cursor[r] = cursor[r] + avail;
                            drop_consumed();
                        end
                    end
                end
                KIND_CLOSE: closed = 1'b1;
                default:    clear_state();
            endcase
        endfunction

        function void match_reply(logic [2:0] st, logic [31:0] smp, logic [47:0] pos,
                                  logic last);
            fifo_reply_t want;
            checked++;
            if (st == STAT_SAMPLE) samples_seen++;
            if (st == STAT_DROPPED) drops_seen++;
            if (st == STAT_BAD_READER) bad_seen++;
            if (replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d sample %h position %h last %0d",
                             st, smp, pos, last);
                return;
            end
            want = replies.pop_front();
            if (want.status != status_t'(st) || want.sample != smp ||
                want.position != pos || want.last != last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected status %0d sample %h position %h last %0d,",
                              " got status %0d sample %h position %h last %0d"},
                             want.status, want.sample, want.position, want.last,
                             st, smp, pos, last);
            end
        endfunction

        function void flag_leftover();
            if (replies.size() != 0) begin
                mismatches += replies.size();
                $display("%0d expected results never arrived.", replies.size());
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   s_tlast = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    sample_fifo_shadow shadow;
    int unsigned       cycle_count = 0;
    int unsigned       burst_left = 0;
    int unsigned       rdy_mode = 0;
    int unsigned       commands_sent = 0;

    multi_reader_sample_fifo_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("tb_multi_reader_sample_fifo_unit: FAIL");
            $finish;
        end
    end

    // The result side is always ready, randomly ready, or follows a fixed stall pattern.
    always @(posedge aclk) begin
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ((cycle_count % 11) >= 6);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            shadow.match_reply(m_tuser, m_tdata[31:0], m_tdata[79:32], m_tlast);
    end

    task automatic send_cmd(kind_t kind, logic [31:0] smp, logic burst_end, logic [2:0] rdr);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            rdy_mode   = $urandom_range(0, 2);
            gap        = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {5'b0, rdr, smp};
        s_tuser  <= kind;
        s_tlast  <= burst_end;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        shadow.apply_command(kind, smp, burst_end, rdr);
        commands_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (shadow.replies.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        shadow.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_traffic(int unsigned count);
        int unsigned done;
        int unsigned pick;
        int unsigned len;
        logic [2:0]  rdr;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = $urandom_range(1, 16);
                for (int unsigned j = 0; j < len; j++)
                    send_cmd(KIND_APPEND, $urandom,
                             (j + 1 == len) || ($urandom_range(0, 7) == 0), 3'($urandom));
                done += len;
            end else if (pick < 90) begin
                if ($urandom_range(0, 7) != 0)
                    rdr = 3'($urandom_range(0, shadow.live_readers() - 1));
                else
                    rdr = 3'($urandom_range(0, 7));
                send_cmd(KIND_READ, $urandom, 1'($urandom), rdr);
                done++;
            end else if (pick < 96) begin
                send_cmd(KIND_CLOSE, $urandom, 1'($urandom), 3'($urandom));
                done++;
            end else begin
                send_cmd(KIND_CLEAR, $urandom, 1'($urandom), 3'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        shadow = new;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults after reset: one reader and the full batch limit.
        send_cmd(KIND_READ, 32'h0, 1'b0, 3'd0);
        send_cmd(KIND_READ, 32'h0, 1'b0, 3'd1);
        send_cmd(KIND_APPEND, 32'h0000_0000, 1'b0, 3'd0);
        send_cmd(KIND_APPEND, 32'hFFFF_FFFF, 1'b1, 3'd7);
        send_cmd(KIND_READ, 32'hFFFF_FFFF, 1'b1, 3'd0);
        send_cmd(KIND_READ, 32'h0, 1'b0, 3'd0);
        send_cmd(KIND_CLOSE, 32'h0, 1'b0, 3'd0);
        send_cmd(KIND_READ, 32'h0, 1'b0, 3'd0);
        send_cmd(KIND_APPEND, 32'hA5A5_A5A5, 1'b1, 3'd0);
        send_cmd(KIND_READ, 32'h0, 1'b0, 3'd0);
        send_cmd(KIND_READ, 32'h0, 1'b0, 3'd7);
        send_cmd(KIND_CLEAR, 32'h0, 1'b0, 3'd0);
        send_cmd(KIND_READ, 32'h0, 1'b0, 3'd0);
        drain();

        write_reg(CFG_ACTIVE_READERS, 8'hAF);
        write_reg(CFG_MAX_BATCH, 8'h81);
        random_traffic(20);
        drain();

        // Reader 0 holds entries back while reader 1 catches up.
        write_reg(CFG_ACTIVE_READERS, 8'h02);
        write_reg(CFG_MAX_BATCH, 8'h00);
        send_cmd(KIND_CLEAR, $urandom, 1'b0, 3'd0);
        for (int unsigned i = 0; i < 24; i++)
            send_cmd(KIND_APPEND, $urandom, (i % 8 == 7), 3'($urandom));
        for (int unsigned i = 0; i < 2; i++) send_cmd(KIND_READ, $urandom, 1'b0, 3'd1);
        for (int unsigned i = 0; i < 2; i++) send_cmd(KIND_READ, $urandom, 1'b0, 3'd0);
        send_cmd(KIND_APPEND, $urandom, 1'b1, 3'd0);
        send_cmd(KIND_APPEND, $urandom, 1'b1, 3'd0);
        drain();

        write_reg(CFG_ACTIVE_READERS, 8'h00);
        random_traffic(10);
        drain();
        write_reg(CFG_ACTIVE_READERS, 8'h05);
        write_reg(CFG_MAX_BATCH, 8'h7F);
        random_traffic(20);
        drain();

        write_reg(CFG_UNMAPPED, 8'h55);
        write_reg(CFG_ACTIVE_READERS, 8'h03);
        write_reg(CFG_MAX_BATCH, 8'h05);
        random_traffic(15);
        drain();

        shadow.flag_leftover();
        $display("Sent %0d commands and checked %0d results, %0d of them samples.",
                 commands_sent, shadow.checked, shadow.samples_seen);
        $display("Saw %0d appends dropped on a full store and %0d reads by inactive readers.",
                 shadow.drops_seen, shadow.bad_seen);
        if (shadow.mismatches == 0) begin
            $display("tb_multi_reader_sample_fifo_unit: PASS");
        end else begin
            $display("tb_multi_reader_sample_fifo_unit: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/mrsf_pkg.sv
sv/mrsf_ram.sv
sv/mrsf_alu.sv
sv/multi_reader_sample_fifo_unit.sv
dv/tb_multi_reader_sample_fifo_unit.sv
